/* rtl/core/safs_pkg.sv */
// Shared constants, codes and types for the sprite animation frame sampler.
// No dependencies.
`timescale 1ns / 1ps

package safs_pkg;

    // Frame table geometry
    localparam int MAX_FRAMES = 256;
    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

    // Port widths
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    // Hash constants
    localparam logic [63:0] HASH_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] HASH_MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] HASH_MUL2   = 64'h94d049bb133111eb;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ID   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE = 1'd1;

    // Sequencer states
    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_HASH_A    = 14'b00000000000010,
        S_HASH_B    = 14'b00000000000100,
        S_HASH_C    = 14'b00000000001000,
        S_MUL       = 14'b00000000010000,
        S_XOR27     = 14'b00000000100000,
        S_XOR31     = 14'b00000001000000,
        S_MOD       = 14'b00000010000000,
        S_ADDT      = 14'b00000100000000,
        S_CLAMP     = 14'b00001000000000,
        S_SRCH      = 14'b00010000000000,
        S_SRCH_WAIT = 14'b00100000000000,
        S_SPR_WAIT  = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } state_t;

endpackage

/* rtl/core/sprite_animation_frame_sampler.sv */
// Sprite animation frame sampler: frame table memories and sample sequencer.
// Depends on safs_pkg.
// Clear and append go straight to the done state and the output register; a
// sample runs a binary search over the table, and a looping sample first adds a
// modulo unit pass (two passes and a hash with a nonzero seed). One item in
// flight at a time; the modulo unit works 1 bit per cycle and each search step
// waits for a registered table read. Reset clears the frame count, total,
// registers and control; the tables need no clearing.
`timescale 1ns / 1ps

module sprite_animation_frame_sampler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [safs_pkg::CMD_W-1:0]        command,
    input  logic [63:0]                       frame_sprite,
    input  logic [31:0]                       frame_duration_ms,
    input  logic [63:0]                       elapsed_ms,
    input  logic [63:0]                       phase_seed,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [safs_pkg::STATUS_W-1:0]     status,
    output logic [63:0]                       sprite_id,
    output logic                              finished,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [safs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                       cfg_data
);
    import safs_pkg::*;

    // Frame table memories
    logic [63:0] spr_mem [MAX_FRAMES];
    logic [63:0] end_mem [MAX_FRAMES];
    logic [63:0] spr_q_reg;
    logic [63:0] end_q_reg;
    logic [ADDR_W-1:0] mem_addr;

    // Architectural state
    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [63:0]      total_reg;
    logic [63:0]      clip_id_reg;
    logic             loop_mode_reg;

    // Datapath registers
    logic [63:0]      t_reg;
    logic [63:0]      seed_reg;
    logic [63:0]      v_reg;
    logic [63:0]      prod_reg;
    logic [1:0]       mstep_reg;
    logic             mul2_reg;
    logic [63:0]      dvd_reg;
    logic [63:0]      rem_reg;
    logic [5:0]       dcnt_reg;
    logic             hash_mod_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] mid_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_finished_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [63:0]         out_sprite_reg;
    logic                out_finished_reg;
    logic                out_valid_reg;

    logic             in_xfer;
    logic             app_ok;
    logic [64:0]      app_sum;
    logic [63:0]      app_end;
    logic [CNT_W-1:0] mid_c;
    logic [CNT_W-1:0] last_idx;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      mul_b_full;
    logic [63:0]      mul_p;
    logic [64:0]      rem_sh;
    logic [64:0]      rem_diff;
    logic [64:0]      t_sum;
    logic [63:0]      hc_v;
    logic             out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign sprite_id = out_sprite_reg;
    assign finished  = out_finished_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Append: saturating running end time
    assign app_ok  = (count_reg < CNT_W'(MAX_FRAMES));
    assign app_sum = {1'b0, total_reg} + {33'b0, frame_duration_ms};
    assign app_end = app_sum[64] ? '1 : app_sum[63:0];

    // Search midpoint and final frame index
    assign mid_c    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign last_idx = (lo_reg >= count_reg) ? (count_reg - CNT_W'(1)) : lo_reg;
    assign mem_addr = (lo_reg < hi_reg) ? mid_c[ADDR_W-1:0] : last_idx[ADDR_W-1:0];

    // Shared 32x32 multiplier: low 64 bits of a 64x64 product in three steps
    assign mul_b_full = mul2_reg ? HASH_MUL2 : HASH_MUL1;
    assign mul_a = (mstep_reg == 2'd2) ? v_reg[63:32] : v_reg[31:0];
    assign mul_b = (mstep_reg == 2'd1) ? mul_b_full[63:32] : mul_b_full[31:0];
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Restoring modulo step
    assign rem_sh   = {rem_reg, dvd_reg[63]};
    assign rem_diff = rem_sh - {1'b0, total_reg};

    assign t_sum = {1'b0, t_reg} + {1'b0, rem_reg};
    assign hc_v  = seed_reg ^ (v_reg + (seed_reg >> 2));

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (in_xfer && command == CMD_APPEND && app_ok)
        begin
            spr_mem[count_reg[ADDR_W-1:0]] <= frame_sprite;
            end_mem[count_reg[ADDR_W-1:0]] <= app_end;
        end
        spr_q_reg <= spr_mem[mem_addr];
        end_q_reg <= end_mem[mem_addr];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_id_reg   <= '0;
            loop_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_CLIP_ID)
                clip_id_reg <= cfg_data;
            else if (cfg_index == CFG_LOOP_MODE)
                loop_mode_reg <= cfg_data[0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            out_status_reg   <= res_status_reg;
            out_finished_reg <= res_finished_reg;
            out_sprite_reg   <= (res_status_reg == ST_DONE) ? v_reg : '0;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            total_reg        <= '0;
            res_status_reg   <= ST_DONE;
            res_finished_reg <= 1'b0;
            t_reg            <= '0;
            seed_reg         <= '0;
            v_reg            <= '0;
            prod_reg         <= '0;
            mstep_reg        <= '0;
            mul2_reg         <= 1'b0;
            dvd_reg          <= '0;
            rem_reg          <= '0;
            dcnt_reg         <= '0;
            hash_mod_reg     <= 1'b0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            mid_reg          <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        res_status_reg   <= ST_DONE;
                        res_finished_reg <= 1'b0;
                        v_reg            <= '0;
                        state_reg        <= S_DONE;
                        t_reg            <= elapsed_ms;
                        seed_reg         <= phase_seed;
                        case (command)
                            CMD_CLEAR:
                            begin
                                count_reg <= '0;
                                total_reg <= '0;
                            end
                            CMD_APPEND:
                            begin
                                if (app_ok)
                                begin
                                    total_reg <= app_end;
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                                else
                                    res_status_reg <= ST_FULL;
                            end
                            CMD_SAMPLE:
                            begin
                                if (count_reg == '0 || total_reg == '0)
                                    res_status_reg <= ST_EMPTY;
                                else if (loop_mode_reg && phase_seed != '0)
                                    state_reg <= S_HASH_A;
                                else if (loop_mode_reg)
                                begin
                                    dvd_reg      <= elapsed_ms;
                                    rem_reg      <= '0;
                                    dcnt_reg     <= '0;
                                    hash_mod_reg <= 1'b0;
                                    state_reg    <= S_MOD;
                                end
                                else
                                    state_reg <= S_CLAMP;
                            end
                            default:
                            begin
                                res_status_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                S_HASH_A:
                begin
                    v_reg     <= clip_id_reg + HASH_GOLDEN;
                    state_reg <= S_HASH_B;
                end
                S_HASH_B:
                begin
                    v_reg     <= v_reg + (seed_reg << 6);
                    state_reg <= S_HASH_C;
                end
                S_HASH_C:
                begin
                    v_reg     <= hc_v ^ (hc_v >> 30);
                    mstep_reg <= 2'd0;
                    mul2_reg  <= 1'b0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (mstep_reg == 2'd0)
                        prod_reg <= mul_p;
                    else
                        prod_reg <= prod_reg + {mul_p[31:0], 32'b0};
                    if (mstep_reg == 2'd2)
                        state_reg <= mul2_reg ? S_XOR31 : S_XOR27;
                    mstep_reg <= mstep_reg + 2'd1;
                end
                S_XOR27:
                begin
                    v_reg     <= prod_reg ^ (prod_reg >> 27);
                    mstep_reg <= 2'd0;
                    mul2_reg  <= 1'b1;
                    state_reg <= S_MUL;
                end
                S_XOR31:
                begin
                    dvd_reg      <= prod_reg ^ (prod_reg >> 31);
                    rem_reg      <= '0;
                    dcnt_reg     <= '0;
                    hash_mod_reg <= 1'b1;
                    state_reg    <= S_MOD;
                end
                S_MOD:
                begin
                    dvd_reg  <= dvd_reg << 1;
                    rem_reg  <= rem_diff[64] ? rem_sh[63:0] : rem_diff[63:0];
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd63)
                        state_reg <= hash_mod_reg ? S_ADDT : S_CLAMP;
                end
                S_ADDT:
                begin
                    dvd_reg      <= t_sum[64] ? '1 : t_sum[63:0];
                    rem_reg      <= '0;
                    dcnt_reg     <= '0;
                    hash_mod_reg <= 1'b0;
                    state_reg    <= S_MOD;
                end
                S_CLAMP:
                begin
                    // Looping clips arrive here with the wrapped time in rem
                    if (loop_mode_reg)
                        t_reg <= rem_reg;
                    else
                    begin
                        res_finished_reg <= (t_reg >= total_reg);
                        if (t_reg >= total_reg - 64'd1)
                            t_reg <= total_reg - 64'd1;
                    end
                    lo_reg    <= '0;
                    hi_reg    <= count_reg;
                    state_reg <= S_SRCH;
                end
                S_SRCH:
                begin
                    mid_reg   <= mid_c;
                    state_reg <= (lo_reg < hi_reg) ? S_SRCH_WAIT : S_SPR_WAIT;
                end
                S_SRCH_WAIT:
                begin
                    if (t_reg < end_q_reg)
                        hi_reg <= mid_reg;
                    else
                        lo_reg <= mid_reg + CNT_W'(1);
                    state_reg <= S_SRCH;
                end
                S_SPR_WAIT:
                begin
                    v_reg     <= spr_q_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAMES))
        else $error("frame count beyond table depth");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH_WAIT) |-> (lo_reg < hi_reg && hi_reg <= count_reg))
        else $error("search window out of range");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("accepted item not taken up");

endmodule
